### rtl/lapi_pkg.sv
`default_nettype none

package lapi_pkg;

  // Field widths
  localparam int unsigned QuotaW    = 16;
  localparam int unsigned CountW    = 16;
  localparam int unsigned IntervalW = 24;
  localparam int unsigned LossW     = 17;
  localparam int unsigned AvgW      = 24;
  localparam int unsigned CreditW   = 9;
  localparam int unsigned LimitW    = 8;
  localparam int unsigned RunW      = 4;
  localparam int unsigned CfgAddrW  = 3;
  localparam int unsigned CfgDataW  = 24;
  localparam int unsigned InDataW   = 16;
  localparam int unsigned OutDataW  = 80;

  // Saturation value of the interval and of the zero-loss run
  localparam logic [IntervalW-1:0] IntervalMax = 24'hFF_FFFF;
  localparam logic [RunW-1:0]      RunMax      = 4'hF;

  // Reciprocals for exact floor division: floor(2^32 / d)
  localparam logic [31:0] Div5Recip  = 32'd858993459;
  localparam logic [31:0] Div11Recip = 32'd390451572;

  // Configuration register indexes
  typedef enum logic [CfgAddrW-1:0] {
    CFG_WAVE_QUOTA   = 3'd0,
    CFG_URGENT_LIMIT = 3'd1,
    CFG_DROP_LIMIT   = 3'd2,
    CFG_ADJUST_LIMIT = 3'd3,
    CFG_MIN_INTERVAL = 3'd4,
    CFG_START_INTV   = 3'd5,
    CFG_ZERO_RUN     = 3'd6
  } cfg_idx_e;

  // Configuration reset values
  localparam logic [QuotaW-1:0]    QuotaRst    = 16'd600;
  localparam logic [AvgW-1:0]      UrgentRst   = 24'd1536;
  localparam logic [AvgW-1:0]      DropRst     = 24'd768;
  localparam logic [LimitW-1:0]    AdjustRst   = 8'd8;
  localparam logic [IntervalW-1:0] MinIntvRst  = 24'd20480;
  localparam logic [IntervalW-1:0] StartIntvRst = 24'd140800;
  localparam logic [RunW-1:0]      ZeroRunRst  = 4'd3;

endpackage

`default_nettype wire

### rtl/loss_adaptive_pacing_interval_top.sv
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid_i/s_axis_tready_o tdata: received_count; tuser: new_session
// m_axis    out  m_axis_tvalid_o/m_axis_tready_i tdata: pacing_interval, wave_loss,
//                                                       loss_average, adjust_credit
// cfg       in   cfg_we_i (no wait)              cfg_addr_i, cfg_wdata_i
//
// Items pass the input, then the result register; one item per cycle if m_axis is ready.
// The whole update of the controller state runs between the input register and the
// result register, so each item sees the state left by the one before it.
// Reset loads the configuration defaults and the session start state; no clearing pass.
// A stalled output holds its result and stops the input register; ready then follows it.
`default_nettype none

module loss_adaptive_pacing_interval_top (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Configuration writes
  input  wire logic                             cfg_we_i,
  input  wire logic [lapi_pkg::CfgAddrW-1:0]    cfg_addr_i,
  input  wire logic [lapi_pkg::CfgDataW-1:0]    cfg_wdata_i,
  // Input items
  input  wire logic                             s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  input  wire logic [lapi_pkg::InDataW-1:0]     s_axis_tdata_i,  // [15:0] received_count
  input  wire logic                             s_axis_tuser_i,  // [0] new_session
  // Result items
  output logic                                  m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  // [23:0] pacing_interval, [40:24] wave_loss, [64:41] loss_average,
  // [73:65] adjust_credit, [79:74] zero
  output logic [lapi_pkg::OutDataW-1:0]         m_axis_tdata_o
);

  // Configuration registers
  logic [lapi_pkg::QuotaW-1:0]    quota_q;
  logic [lapi_pkg::AvgW-1:0]      urgent_q;
  logic [lapi_pkg::AvgW-1:0]      drop_q;
  logic [lapi_pkg::LimitW-1:0]    adjust_q;
  logic [lapi_pkg::IntervalW-1:0] min_intv_q;
  logic [lapi_pkg::IntervalW-1:0] start_intv_q;
  logic [lapi_pkg::RunW-1:0]      zero_need_q;

  // Input register
  logic                        in_valid_q;
  logic                        new_session_q;
  logic [lapi_pkg::CountW-1:0] rcount_q;

  // Controller state
  logic [lapi_pkg::IntervalW-1:0] interval_q, interval_d;
  logic [lapi_pkg::AvgW-1:0]      avg_q, avg_d;
  logic [lapi_pkg::CreditW-1:0]   credit_q, credit_d;
  logic [lapi_pkg::RunW-1:0]      zero_run_q, zero_run_d;

  // Result register
  logic                          out_valid_q;
  logic [lapi_pkg::OutDataW-1:0] out_data_q;

  logic advance;

  // Datapath signals
  logic [lapi_pkg::IntervalW-1:0] iv_base;
  logic [lapi_pkg::AvgW-1:0]      avg_base;
  logic [lapi_pkg::CreditW-1:0]   credit_base;
  logic [lapi_pkg::RunW-1:0]      run_base;
  logic signed [lapi_pkg::LossW-1:0] loss;
  logic                           loss_neg;
  logic                           loss_zero;
  logic [lapi_pkg::AvgW-1:0]      lq_pos;
  logic [26:0]                    avg_sum;
  logic                           credit_ok;
  logic                           grow_urgent;
  logic                           grow_drop;
  logic [lapi_pkg::IntervalW-1:0] grow2;
  logic [26:0]                    x7;
  logic [58:0]                    prod5;
  logic [24:0]                    q5_est;
  logic [26:0]                    r5;
  logic [24:0]                    q5;
  logic [lapi_pkg::IntervalW-1:0] grow7;
  logic [27:0]                    x10;
  logic [59:0]                    prod11;
  logic [24:0]                    q11_est;
  logic [27:0]                    r11;
  logic [24:0]                    q11;
  logic [27:0]                    min11;
  logic                           shrink_ok;
  logic [lapi_pkg::CreditW-1:0]   credit_grown;
  logic [lapi_pkg::RunW-1:0]      run_inc;
  logic                           shrink_now;

  // Handshake: advance moves an item from the input register to the result register
  assign advance         = in_valid_q & (~out_valid_q | m_axis_tready_i);
  assign s_axis_tready_o = ~in_valid_q | advance;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // Configuration port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quota_q      <= lapi_pkg::QuotaRst;
      urgent_q     <= lapi_pkg::UrgentRst;
      drop_q       <= lapi_pkg::DropRst;
      adjust_q     <= lapi_pkg::AdjustRst;
      min_intv_q   <= lapi_pkg::MinIntvRst;
      start_intv_q <= lapi_pkg::StartIntvRst;
      zero_need_q  <= lapi_pkg::ZeroRunRst;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        lapi_pkg::CFG_WAVE_QUOTA:   quota_q      <= cfg_wdata_i[lapi_pkg::QuotaW-1:0];
        lapi_pkg::CFG_URGENT_LIMIT: urgent_q     <= cfg_wdata_i;
        lapi_pkg::CFG_DROP_LIMIT:   drop_q       <= cfg_wdata_i;
        lapi_pkg::CFG_ADJUST_LIMIT: adjust_q     <= cfg_wdata_i[lapi_pkg::LimitW-1:0];
        lapi_pkg::CFG_MIN_INTERVAL: min_intv_q   <= cfg_wdata_i;
        lapi_pkg::CFG_START_INTV:   start_intv_q <= cfg_wdata_i;
        lapi_pkg::CFG_ZERO_RUN:     zero_need_q  <= cfg_wdata_i[lapi_pkg::RunW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      new_session_q <= s_axis_tuser_i;
      rcount_q      <= s_axis_tdata_i[lapi_pkg::CountW-1:0];
    end
  end

  // Start state reload for a new session
  assign iv_base     = new_session_q ? start_intv_q : interval_q;
  assign avg_base    = new_session_q ? '0 : avg_q;
  assign credit_base = new_session_q ? '0 : credit_q;
  assign run_base    = new_session_q ? '0 : zero_run_q;

  // Wave loss and its Q16.8 form (only used when not negative)
  assign loss      = signed'({1'b0, quota_q}) - signed'({1'b0, rcount_q});
  assign loss_neg  = loss[lapi_pkg::LossW-1];
  assign loss_zero = (loss == '0);
  assign lq_pos    = {loss[15:0], 8'h00};

  // Average: floor((3*avg + L) / 4), held when the loss is negative
  assign avg_sum = {3'b000, avg_base} + {2'b00, avg_base, 1'b0} + {3'b000, lq_pos};
  assign avg_d   = loss_neg ? avg_base : avg_sum[25:2];

  // Growth decisions
  assign credit_ok   = credit_base < {1'b0, adjust_q};
  assign grow_urgent = ~loss_neg && (avg_d > urgent_q) && (lq_pos > urgent_q) && credit_ok;
  assign grow_drop   = ~loss_neg && (avg_d > drop_q) && (lq_pos > drop_q) && credit_ok;

  // Doubling with saturation
  assign grow2 = iv_base[lapi_pkg::IntervalW-1] ? lapi_pkg::IntervalMax
                                                : {iv_base[lapi_pkg::IntervalW-2:0], 1'b0};

  // Growth by 7/5: reciprocal estimate, then one correction step
  assign x7     = {iv_base, 3'b000} - {3'b000, iv_base};
  assign prod5  = 59'(x7) * 59'(lapi_pkg::Div5Recip);
  assign q5_est = prod5[56:32];
  assign r5     = x7 - ({2'b00, q5_est} + {q5_est, 2'b00});
  assign q5     = q5_est + {24'd0, (r5 >= 27'd5)};
  assign grow7  = (q5 > {1'b0, lapi_pkg::IntervalMax}) ? lapi_pkg::IntervalMax
                                                       : q5[lapi_pkg::IntervalW-1:0];

  // Shrink by 10/11 with the same estimate-and-correct scheme
  assign x10     = {1'b0, iv_base, 3'b000} + {3'b000, iv_base, 1'b0};
  assign prod11  = 60'(x10) * 60'(lapi_pkg::Div11Recip);
  assign q11_est = prod11[56:32];
  assign r11     = x10 - ({q11_est, 3'b000} + {2'b00, q11_est, 1'b0} + {3'b000, q11_est});
  assign q11     = q11_est + {24'd0, (r11 >= 28'd11)};
  assign min11   = {1'b0, min_intv_q, 3'b000} + {3'b000, min_intv_q, 1'b0}
                 + {4'b0000, min_intv_q};
  assign shrink_ok = x10 > min11;

  // Credit after growth, zero-loss run
  assign credit_grown = grow_urgent ? credit_base + 9'd2 :
                        grow_drop   ? credit_base + 9'd1 : credit_base;
  assign run_inc      = (run_base == lapi_pkg::RunMax) ? run_base : run_base + 4'd1;
  assign shrink_now   = loss_zero && (run_inc >= zero_need_q);

  // Next state
  always_comb begin
    interval_d = iv_base;
    credit_d   = credit_grown;
    zero_run_d = '0;
    if (loss_zero) begin
      if (credit_grown != '0) begin
        credit_d = credit_grown - 9'd1;
      end
      if (shrink_now) begin
        interval_d = shrink_ok ? q11[lapi_pkg::IntervalW-1:0] : min_intv_q;
      end else begin
        zero_run_d = run_inc;
      end
    end else if (grow_urgent) begin
      interval_d = grow2;
    end else if (grow_drop) begin
      interval_d = grow7;
    end
  end

  // State update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= lapi_pkg::StartIntvRst;
      avg_q      <= '0;
      credit_q   <= '0;
      zero_run_q <= '0;
    end else if (advance) begin
      interval_q <= interval_d;
      avg_q      <= avg_d;
      credit_q   <= credit_d;
      zero_run_q <= zero_run_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {6'd0, credit_d, avg_d, loss, interval_d};
    end
  end

  // Checks
  a_advance_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("result missing after an item advanced");

  a_shrink_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && shrink_now) |-> (interval_d >= min_intv_q))
    else $error("shrunk interval fell below the minimum");

  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    credit_q <= 9'd257)
    else $error("adjustment credit out of range");

  a_run_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    zero_run_q != lapi_pkg::RunMax)
    else $error("zero-loss run reached its ceiling without a shrink");

endmodule

`default_nettype wire
